// ===== rtl/atls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atls_pkg: shared types and constants for the tagged LRU set
// Way count, field widths, request modes, and the structs passed along the
// cell chain and into each cell for updates.
// ----------------------------------------------------------------------------
package atls_pkg;

	localparam int WAYS    = 16;
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NUM_W   = $clog2(WAYS + 1);
	localparam int TAG_W   = 40;
	localparam int STAMP_W = 64;
	localparam int COUNT_W = 5;
	localparam int CFG_W   = 5;
	localparam int MODE_W  = 2;

	localparam logic [MODE_W-1:0] MODE_FIND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REPL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MARK = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	// Search token that walks the chain, one cell per cycle
	typedef struct packed {
		logic               vld;
		logic [MODE_W-1:0]  mode;
		logic [TAG_W-1:0]   tag;
		logic               apx;
		logic               found;
		logic [WAY_W-1:0]   fidx;
		logic               fapx;
		logic [STAMP_W-1:0] best;
		logic [WAY_W-1:0]   bidx;
		logic               bapx;
	} token_t;

	// Update broadcast to all cells; only the addressed cell takes it
	typedef struct packed {
		logic               en;
		logic [WAY_W-1:0]   idx;
		logic               set_tag;
		logic [TAG_W-1:0]   tag;
		logic               set_stamp;
		logic [STAMP_W-1:0] stamp;
		logic               set_apx;
		logic               apx;
	} wr_t;

endpackage

// ===== rtl/atls_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atls_cell: one way of the set
// Holds tag, use stamp and approximate bit; folds its way into the passing
// search token and registers it for the next cell in the following cycle.
// ----------------------------------------------------------------------------
module atls_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [atls_pkg::WAY_W-1:0] idx,
	input  logic                    live,
	input  atls_pkg::token_t        tok_in,
	input  atls_pkg::wr_t           wr,
	output atls_pkg::token_t        tok_out
);
	import atls_pkg::*;

	logic [TAG_W-1:0]   tag_q;
	logic [STAMP_W-1:0] stamp_q;
	logic               apx_q;
	token_t             tok_q;
	token_t             tok_d;
	logic               match;
	logic               older;

	assign match = (tag_q == tok_in.tag);
	assign older = (idx == '0) || (stamp_q < tok_in.best);

	always_comb begin
		tok_d = tok_in;
		if (tok_in.vld && live) begin
			if ((tok_in.mode == MODE_FIND || tok_in.mode == MODE_MARK)
					&& !tok_in.found && match) begin
				tok_d.found = 1'b1;
				tok_d.fidx  = idx;
				tok_d.fapx  = apx_q;
			end
			// strict compare keeps the lowest index on a tie
			if (tok_in.mode == MODE_REPL && older) begin
				tok_d.best = stamp_q;
				tok_d.bidx = idx;
				tok_d.bapx = apx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			tag_q   <= '0;
			stamp_q <= '0;
			apx_q   <= 1'b0;
		end else begin
			tok_q <= tok_d;
			if (wr.en && wr.idx == idx) begin
				if (wr.set_tag)   tag_q   <= wr.tag;
				if (wr.set_stamp) stamp_q <= wr.stamp;
				if (wr.set_apx)   apx_q   <= wr.apx;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== rtl/approx_tagged_lru_set.sv =====
`timescale 1ns / 1ps
// Path: an accepted request is registered as a search token, walks the chain of
//   way cells one cell per cycle, lands in the result register and, once the
//   output slot is free, updates the ways; only then is a new request taken.
// Reset: all ways tag 0, stamp 0, precise; stamp counter 1; active_ways 16.
// No clearing pass: the block takes requests right after reset.
// ----------------------------------------------------------------------------
// approx_tagged_lru_set: one cache set with timestamp LRU and approx bits
// Controller, request/result registers, running counts and the cell chain.
// ----------------------------------------------------------------------------
module approx_tagged_lru_set (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [atls_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [atls_pkg::MODE_W-1:0] mode,
	input  logic [atls_pkg::TAG_W-1:0]  line_tag,
	input  logic                        approx_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic                        hit_approx,
	output logic [atls_pkg::COUNT_W-1:0] approx_count,
	output logic [atls_pkg::COUNT_W-1:0] precise_count
);
	import atls_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SWEEP  = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   active_q;
	logic [NUM_W-1:0]   live_n;
	logic [STAMP_W-1:0] next_stamp_q;
	logic [COUNT_W-1:0] apx_cnt_q;
	logic [COUNT_W-1:0] pre_cnt_q;
	token_t             tok_q;
	token_t             tok_new;
	token_t             res_q;
	token_t             chain [WAYS+1];
	logic [WAYS-1:0]    chain_vld;
	wr_t                wr;
	logic               slot_free;
	logic               finish;
	logic               out_valid_q;
	logic               hit_q;
	logic               hit_apx_q;
	logic               bump_stamp;
	logic               old_apx;

	// Clamp the configured way count to 1..WAYS
	always_comb begin
		if (active_q == '0)
			live_n = NUM_W'(1);
		else if (int'(active_q) > WAYS)
			live_n = NUM_W'(WAYS);
		else
			live_n = NUM_W'(active_q);
	end

	// Fresh search token for an accepted request
	always_comb begin
		tok_new      = '0;
		tok_new.vld  = 1'b1;
		tok_new.mode = mode;
		tok_new.tag  = line_tag;
		tok_new.apx  = approx_in;
	end

	assign chain[0] = tok_q;

	genvar gi;
	generate
		for (gi = 0; gi < WAYS; gi++) begin : g_way
			logic [WAY_W-1:0] cell_idx;
			assign cell_idx     = WAY_W'(gi);
			assign chain_vld[gi] = chain[gi].vld;
			atls_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (cell_idx),
				.live    (NUM_W'(gi) < live_n),
				.tok_in  (chain[gi]),
				.wr      (wr),
				.tok_out (chain[gi+1])
			);
		end
	endgenerate

	assign in_ready  = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign finish    = (state_q == ST_FINISH) && slot_free;

	// Build the way update from the finished search
	always_comb begin
		wr         = '0;
		bump_stamp = 1'b0;
		old_apx    = 1'b0;
		wr.tag     = res_q.tag;
		wr.stamp   = next_stamp_q;
		wr.apx     = res_q.apx;
		if (finish) begin
			unique case (res_q.mode)
				MODE_FIND: begin
					wr.en        = res_q.found;
					wr.idx       = res_q.fidx;
					wr.set_stamp = 1'b1;
					bump_stamp   = res_q.found;
				end
				MODE_REPL: begin
					wr.en        = 1'b1;
					wr.idx       = res_q.bidx;
					wr.set_tag   = 1'b1;
					wr.set_stamp = 1'b1;
					wr.set_apx   = 1'b1;
					bump_stamp   = 1'b1;
					old_apx      = res_q.bapx;
				end
				MODE_MARK: begin
					wr.en      = res_q.found;
					wr.idx     = res_q.fidx;
					wr.set_apx = 1'b1;
					old_apx    = res_q.fapx;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_q     <= CFG_W'(16);
			next_stamp_q <= STAMP_W'(1);
			apx_cnt_q    <= '0;
			pre_cnt_q    <= COUNT_W'(WAYS);
			tok_q        <= '0;
			res_q        <= '0;
			out_valid_q  <= 1'b0;
			hit_q        <= 1'b0;
			hit_apx_q    <= 1'b0;
		end else begin
			if (cfg_we) active_q <= cfg_wdata;
			tok_q       <= (in_valid && in_ready) ? tok_new : '0;
			out_valid_q <= finish || (out_valid_q && !out_ready);

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					// hold until the token leaves the last cell
					if (chain[WAYS].vld) begin
						res_q   <= chain[WAYS];
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						hit_q       <= (res_q.mode == MODE_FIND) && res_q.found;
						hit_apx_q   <= (res_q.mode == MODE_FIND) && res_q.found
							&& res_q.fapx;
						if (bump_stamp) next_stamp_q <= next_stamp_q + STAMP_W'(1);
						if (wr.en && wr.set_apx && (old_apx != wr.apx)) begin
							if (wr.apx) begin
								apx_cnt_q <= apx_cnt_q + COUNT_W'(1);
								pre_cnt_q <= pre_cnt_q - COUNT_W'(1);
							end else begin
								apx_cnt_q <= apx_cnt_q - COUNT_W'(1);
								pre_cnt_q <= pre_cnt_q + COUNT_W'(1);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign hit_approx    = hit_apx_q;
	assign approx_count  = apx_cnt_q;
	assign precise_count = pre_cnt_q;

	// At most one search token in the chain at any time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({chain[WAYS].vld, chain_vld}))
		else $error("more than one search token in flight");

	// The counts always add up to the way count
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		COUNT_W'(apx_cnt_q + pre_cnt_q) == COUNT_W'(WAYS))
		else $error("approx and precise counts out of balance");

	// An accepted request enters the chain in the next cycle
	a_inject: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> tok_q.vld && state_q == ST_SWEEP)
		else $error("accepted request not injected");

	// No token is in flight while idle or finishing
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_SWEEP |-> !(|chain_vld) && !chain[WAYS].vld)
		else $error("token in chain outside sweep");

	// Ways are only updated while finishing a request
	a_wr_finish: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> state_q == ST_FINISH && slot_free)
		else $error("way update outside finish");

endmodule

// ===== tb/sv/tb_approx_tagged_lru_set.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_approx_tagged_lru_set: self-checking bench for the tagged LRU cache set
// Drives find, replace, mark and no-op requests through the valid/ready
// handshake, with random idle bursts on both sides. A behavioral copy of the
// set works out each result the directed table lacks; each is compared field
// by field in order. A short directed table runs first, then random phases at
// several active-way settings, including zero and values beyond the way count.
// ----------------------------------------------------------------------------
module tb_approx_tagged_lru_set;
	import atls_pkg::*;

	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 190;
	localparam int POOL        = 12;

	typedef struct packed {
		logic               hit;
		logic               hit_approx;
		logic [COUNT_W-1:0] approx_count;
		logic [COUNT_W-1:0] precise_count;
	} set_result_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TAG_W-1:0]  tag;
		logic              apx;
		logic              known;
		set_result_t       res;
	} access_row_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                cfg_we        = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata     = '0;
	logic                in_valid      = 1'b0;
	logic                in_ready;
	logic [MODE_W-1:0]   mode          = MODE_FIND;
	logic [TAG_W-1:0]    line_tag      = '0;
	logic                approx_in     = 1'b0;
	logic                out_valid;
	logic                out_ready     = 1'b0;
	logic                hit;
	logic                hit_approx;
	logic [COUNT_W-1:0]  approx_count;
	logic [COUNT_W-1:0]  precise_count;

	// behavioral copy of the set
	logic [TAG_W-1:0]    tag_mem   [WAYS];
	logic [STAMP_W-1:0]  stamp_mem [WAYS];
	logic                apx_mem   [WAYS];
	logic [STAMP_W-1:0]  stamp_ctr;
	int                  n_apx;
	int                  n_prec;
	logic [CFG_W-1:0]    live_cfg;

	set_result_t         results_due [$];
	access_row_t         dir_rows [$];
	logic [TAG_W-1:0]    tag_pool [POOL];
	int                  fail_count = 0;
	bit                  tx_idle    = 1'b0;
	bit                  rx_idle    = 1'b0;
	int                  rx_hold    = 0;
	set_result_t         due;

	approx_tagged_lru_set dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.line_tag      (line_tag),
		.approx_in     (approx_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.hit_approx    (hit_approx),
		.approx_count  (approx_count),
		.precise_count (precise_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic void queue_due(input set_result_t r);
		results_due = {results_due, r};
	endfunction

	function automatic void add_row(input access_row_t r);
		dir_rows = {dir_rows, r};
	endfunction

	function automatic void write_way_apx(input int w, input logic a);
		if (!apx_mem[w] && a) begin
			n_apx++;
			n_prec--;
		end else if (apx_mem[w] && !a) begin
			n_apx--;
			n_prec++;
		end
		apx_mem[w] = a;
	endfunction

	function automatic set_result_t predict_access(input logic [MODE_W-1:0] m,
			input logic [TAG_W-1:0] t, input logic a);
		int          lim;
		int          victim;
		bit          done;
		set_result_t r;
		r = '0;
		done = 1'b0;
		lim = (live_cfg == 0) ? 1 : ((live_cfg > WAYS) ? WAYS : int'(live_cfg));
		case (m)
			MODE_FIND: begin
				for (int w = 0; w < lim; w++) begin
					if (!done && tag_mem[w] == t) begin
						stamp_mem[w] = stamp_ctr;
						stamp_ctr++;
						r.hit = 1'b1;
						r.hit_approx = apx_mem[w];
						done = 1'b1;
					end
				end
			end
			MODE_REPL: begin
				victim = 0;
				for (int w = 1; w < lim; w++)
					if (stamp_mem[w] < stamp_mem[victim])
						victim = w;
				tag_mem[victim] = t;
				stamp_mem[victim] = stamp_ctr;
				stamp_ctr++;
				write_way_apx(victim, a);
			end
			MODE_MARK: begin
				for (int w = 0; w < lim; w++) begin
					if (!done && tag_mem[w] == t) begin
						write_way_apx(w, a);
						done = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		r.approx_count = n_apx[COUNT_W-1:0];
		r.precise_count = n_prec[COUNT_W-1:0];
		return r;
	endfunction

	task automatic issue_request(input logic [MODE_W-1:0] m, input logic [TAG_W-1:0] t,
			input logic a, input logic known, input set_result_t known_res);
		set_result_t p;
		int          gap;
		in_valid  <= 1'b1;
		mode      <= m;
		line_tag  <= t;
		approx_in <= a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		p = predict_access(m, t, a);
		queue_due(known ? known_res : p);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic set_active_ways(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		live_cfg = v;
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$error("result: none expected, got hit %0d hit_approx %0d", hit, hit_approx);
				fail_count++;
			end else begin
				due = results_due.pop_front();
				if (hit !== due.hit) begin
					$error("hit: expected %0d, got %0d", due.hit, hit);
					fail_count++;
				end
				if (hit_approx !== due.hit_approx) begin
					$error("hit_approx: expected %0d, got %0d", due.hit_approx, hit_approx);
					fail_count++;
				end
				if (approx_count !== due.approx_count) begin
					$error("approx_count: expected %0d, got %0d",
						due.approx_count, approx_count);
					fail_count++;
				end
				if (precise_count !== due.precise_count) begin
					$error("precise_count: expected %0d, got %0d",
						due.precise_count, precise_count);
					fail_count++;
				end
			end
		end
		if (!rx_idle) begin
			out_ready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			rx_hold = $urandom_range(1, 10) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		access_row_t       row;
		logic [MODE_W-1:0] m;
		logic [TAG_W-1:0]  t;
		logic [CFG_W-1:0]  cfg_v;
		int                r;

		for (int w = 0; w < WAYS; w++) begin
			tag_mem[w] = '0;
			stamp_mem[w] = '0;
			apx_mem[w] = 1'b0;
		end
		stamp_ctr = 64'd1;
		n_apx = 0;
		n_prec = WAYS;
		live_cfg = 5'd16;

		// directed table: mode, tag, approx, known, hit, hit_approx, counts
		add_row({MODE_FIND, 40'h0,          1'b0, 1'b1, 1'b1, 1'b0, 5'd0, 5'd16});
		add_row({MODE_FIND, 40'hFFFFFFFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 5'd0, 5'd16});
		add_row({MODE_REPL, 40'hFFFFFFFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 5'd1, 5'd15});
		add_row({MODE_FIND, 40'hFFFFFFFFFF, 1'b0, 1'b1, 1'b1, 1'b1, 5'd1, 5'd15});
		add_row({MODE_MARK, 40'hFFFFFFFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 5'd0, 5'd16});
		add_row({MODE_MARK, 40'h5,          1'b1, 1'b1, 1'b0, 1'b0, 5'd0, 5'd16});
		add_row({MODE_NONE, 40'hFFFFFFFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 5'd0, 5'd16});
		add_row({MODE_MARK, 40'h0,          1'b1, 1'b1, 1'b0, 1'b0, 5'd1, 5'd15});
		add_row({MODE_FIND, 40'h0,          1'b0, 1'b1, 1'b1, 1'b1, 5'd1, 5'd15});
		add_row({MODE_REPL, 40'hA5A5A5A5A5, 1'b1, 1'b1, 1'b0, 1'b0, 5'd2, 5'd14});
		add_row({MODE_FIND, 40'h0,          1'b1, 1'b1, 1'b1, 1'b1, 5'd2, 5'd14});
		add_row({MODE_FIND, 40'hA5A5A5A5A5, 1'b0, 1'b1, 1'b1, 1'b1, 5'd2, 5'd14});
		add_row({MODE_REPL, 40'h0,          1'b0, 1'b0, 12'h0});
		add_row({MODE_REPL, 40'h5A5A5A5A5A, 1'b1, 1'b0, 12'h0});
		add_row({MODE_REPL, 40'h123456789A, 1'b1, 1'b0, 12'h0});
		add_row({MODE_FIND, 40'h5A5A5A5A5A, 1'b0, 1'b0, 12'h0});
		add_row({MODE_MARK, 40'h123456789A, 1'b0, 1'b0, 12'h0});
		add_row({MODE_REPL, 40'hFFFFFFFFFF, 1'b0, 1'b0, 12'h0});
		add_row({MODE_FIND, 40'hFFFFFFFFFF, 1'b1, 1'b0, 12'h0});
		add_row({MODE_NONE, 40'h0,          1'b0, 1'b0, 12'h0});
		add_row({MODE_MARK, 40'hA5A5A5A5A5, 1'b0, 1'b0, 12'h0});
		add_row({MODE_FIND, 40'hA5A5A5A5A5, 1'b0, 1'b0, 12'h0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			issue_request(row.mode, row.tag, row.apx, row.known, row.res);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: cfg_v = 5'd1;
				1: cfg_v = 5'd16;
				2: cfg_v = 5'd0;
				3: cfg_v = 5'd31;
				4: cfg_v = 5'd8;
				5: cfg_v = 5'd3;
				6: cfg_v = 5'd17;
				7: cfg_v = 5'd12;
				8: cfg_v = 5'($urandom_range(1, 16));
				default: cfg_v = 5'd16;
			endcase
			set_active_ways(cfg_v);
			// no idling at all in the closing phase
			tx_idle = (ph != PHASES - 1) && ($urandom_range(0, 4) != 0);
			rx_idle = (ph != PHASES - 1) && ($urandom_range(0, 4) != 0);
			tag_pool[0] = '0;
			tag_pool[1] = '1;
			for (int p = 2; p < POOL; p++)
				tag_pool[p] = TAG_W'({$urandom, $urandom});
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// mostly pool tags so finds and marks hit installed lines
				if ($urandom_range(0, 9) < 8)
					t = tag_pool[$urandom_range(0, POOL - 1)];
				else
					t = TAG_W'({$urandom, $urandom});
				r = $urandom_range(0, 19);
				if (r < 8)
					m = MODE_FIND;
				else if (r < 14)
					m = MODE_REPL;
				else if (r < 18)
					m = MODE_MARK;
				else
					m = MODE_NONE;
				issue_request(m, t, 1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== approx_tagged_lru_set.f =====
rtl/atls_pkg.sv
rtl/atls_cell.sv
rtl/approx_tagged_lru_set.sv
tb/sv/tb_approx_tagged_lru_set.sv
